>>> src/vrf_pkg.sv
// shared types and constants of the variable record fifo
// no dependencies; used by the channel interfaces and the top level
`timescale 1ns / 1ps
`default_nettype none

package vrf_pkg;

	// built size of the record store
	localparam int BUILT_SLOTS      = 16;
	localparam int MAX_RECORD_BYTES = 64;

	localparam int SLOT_W  = (BUILT_SLOTS > 1) ? $clog2(BUILT_SLOTS) : 1;
	localparam int OFF_W   = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
	localparam int BADDR_W = SLOT_W + OFF_W;

	// field widths
	localparam int OP_W    = 2;
	localparam int LEN_W   = 7;
	localparam int BYTE_W  = 8;
	localparam int CAP_W   = 16;
	localparam int STAT_W  = 3;
	localparam int CNT_W   = 5;
	localparam int DEPTH_W = 5;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [LEN_W-1:0]   MAX_LEN          = LEN_W'(MAX_RECORD_BYTES);
	localparam logic [DEPTH_W-1:0] DEPTH_MAX        = DEPTH_W'(BUILT_SLOTS);
	localparam logic [LEN_W-1:0]   RECORD_BYTES_RST = LEN_W'(64);
	localparam logic [DEPTH_W-1:0] SLOT_LIM_RST     = DEPTH_W'(16);

	typedef enum logic [OP_W-1:0] {
		OP_PUSH  = 2'd0,
		OP_POP   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_QUERY = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		RS_INSERTED     = 3'd0,
		RS_FULL         = 3'd1,
		RS_TOO_LONG     = 3'd2,
		RS_READ_OK      = 3'd3,
		RS_EMPTY        = 3'd4,
		RS_OUT_TOO_LONG = 3'd5,
		RS_CLEARED      = 3'd6,
		RS_COUNT        = 3'd7
	} status_t;

	typedef enum logic [0:0] {
		REG_RECORD_BYTES = 1'b0,
		REG_SLOT_LIM     = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_POP_LEN,
		FSM_POP_STREAM
	} fsm_t;

	typedef struct packed {
		status_t             status;
		logic [LEN_W-1:0]    record_length;
		logic [BYTE_W-1:0]   data_byte;
		logic                byte_valid;
		logic                last_out;
		logic [CNT_W-1:0]    element_count;
	} result_t;

endpackage

`default_nettype wire

>>> src/vrf_cmd_if.sv
// command channel: one push byte, pop, clear or query per item
// depends on vrf_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface vrf_cmd_if import vrf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     opcode;
	logic [LEN_W-1:0]    push_length;
	logic [BYTE_W-1:0]   data_byte_in;
	logic                last_in;
	logic [CAP_W-1:0]    dest_capacity;

	modport source (
		output valid, opcode, push_length, data_byte_in, last_in, dest_capacity,
		input  ready
	);

	modport sink (
		input  valid, opcode, push_length, data_byte_in, last_in, dest_capacity,
		output ready
	);
endinterface

`default_nettype wire

>>> src/vrf_rsp_if.sv
// result channel: status, popped bytes and count
// depends on vrf_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface vrf_rsp_if import vrf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic [LEN_W-1:0]    record_length;
	logic [BYTE_W-1:0]   data_byte;
	logic                byte_valid;
	logic                last_out;
	logic [CNT_W-1:0]    element_count;

	modport source (
		output valid, status, record_length, data_byte, byte_valid, last_out,
		       element_count,
		input  ready
	);

	modport sink (
		input  valid, status, record_length, data_byte, byte_valid, last_out,
		       element_count,
		output ready
	);
endinterface

`default_nettype wire

>>> src/variable_record_fifo_unit.sv
// top level of the variable record fifo: length and byte memories, control
// depends on vrf_pkg, vrf_cmd_if and vrf_rsp_if
`timescale 1ns / 1ps
`default_nettype none

// channel   dir   handshake      carries
// cmd       in    valid/ready    opcode, push_length, data_byte_in, last_in, dest_capacity
// rsp       out   valid/ready    status, record_length, data_byte, byte_valid, last_out,
//                                element_count
// apb       in    psel/penable   record_bytes at 0x0, slot limit at 0x4
//
// push, clear and query take one cycle per item; a push byte goes straight into
// the byte memory and a record yields its single result on commit or refusal
// pop first reads the head length from the length memory, then takes one
// cycle per byte through the registered read port of the byte memory
// reset clears pointers, flags and config to their defaults; memories hold no reset
// cmd is taken only in idle with the result register free or draining; a stalled
// rsp holds the pop stream, the byte read register keeps the pending byte

module variable_record_fifo_unit import vrf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	vrf_cmd_if.sink                 cmd,
	vrf_rsp_if.source               rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	// configuration
	logic [LEN_W-1:0]   rec_bytes_q;
	logic [DEPTH_W-1:0] slot_lim_q;
	logic               cfg_wr;
	cfg_reg_t           cfg_sel;

	// queue state
	logic [SLOT_W-1:0]  rd_slot_q, rd_slot_d;
	logic [SLOT_W-1:0]  wr_slot_q, wr_slot_d;
	logic               full_q, full_d;
	logic               empty_q, empty_d;
	logic [CNT_W-1:0]   count_q, count_d;

	// push tracking
	logic               push_act_q, push_act_d;
	logic               push_rej_q, push_rej_d;
	logic [OFF_W-1:0]   push_off_q, push_off_d;
	logic [LEN_W-1:0]   push_tgt_q, push_tgt_d;

	// pop sequencer
	fsm_t               state_q, state_d;
	logic [CAP_W-1:0]   cap_q, cap_d;
	logic [LEN_W-1:0]   pop_len_q, pop_len_d;
	logic [OFF_W-1:0]   pop_idx_q, pop_idx_d;

	// memories and their ports
	logic [LEN_W-1:0]   len_mem [0:(1 << SLOT_W)-1];
	logic [BYTE_W-1:0]  byte_mem [0:(1 << BADDR_W)-1];
	logic [LEN_W-1:0]   len_rd_q;
	logic [BYTE_W-1:0]  byte_rd_q;
	logic               lwr_en;
	logic [LEN_W-1:0]   lwr_data;
	logic               bwr_en;
	logic [BADDR_W-1:0] bwr_addr;
	logic               brd_en;
	logic [BADDR_W-1:0] brd_addr;

	// result register
	result_t            out_q, res;
	logic               out_valid_q;
	logic               out_free;
	logic               load_out;

	// working values
	logic [LEN_W-1:0]   eff_bytes;
	logic [DEPTH_W-1:0] eff_depth;
	logic [DEPTH_W-1:0] wr_inc, rd_inc;
	logic [SLOT_W-1:0]  wr_next, rd_next;
	logic               accept;
	op_t                op;
	logic [OFF_W-1:0]   off_cur;
	logic [LEN_W-1:0]   tgt_cur;
	logic [LEN_W-1:0]   push_cnt;
	logic [LEN_W-1:0]   head_len;
	logic [LEN_W-1:0]   idx_plus;
	logic               do_commit;
	logic [LEN_W-1:0]   commit_len;
	logic               do_pop_done;

	// ------------------------------------------------------------------
	// configuration port
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_sel = cfg_reg_t'(paddr[2]);

	always_comb begin
		unique case (cfg_sel)
			REG_RECORD_BYTES: prdata = PDATA_W'(rec_bytes_q);
			REG_SLOT_LIM:     prdata = PDATA_W'(slot_lim_q);
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_bytes_q <= RECORD_BYTES_RST;
			slot_lim_q  <= SLOT_LIM_RST;
		end else if (cfg_wr) begin
			unique case (cfg_sel)
				REG_RECORD_BYTES: rec_bytes_q <= pwdata[LEN_W-1:0];
				REG_SLOT_LIM:     slot_lim_q  <= pwdata[DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	// out-of-range settings fold onto the built limits, a zero depth onto one slot
	assign eff_bytes = (rec_bytes_q > MAX_LEN) ? MAX_LEN : rec_bytes_q;
	assign eff_depth = (slot_lim_q == '0) ? DEPTH_W'(1) :
	                   (slot_lim_q > DEPTH_MAX) ? DEPTH_MAX : slot_lim_q;

	// slot pointers wrap at the active depth
	assign wr_inc  = DEPTH_W'(wr_slot_q) + DEPTH_W'(1);
	assign rd_inc  = DEPTH_W'(rd_slot_q) + DEPTH_W'(1);
	assign wr_next = (wr_inc >= eff_depth) ? '0 : wr_inc[SLOT_W-1:0];
	assign rd_next = (rd_inc >= eff_depth) ? '0 : rd_inc[SLOT_W-1:0];

	// ------------------------------------------------------------------
	// handshake
	// ------------------------------------------------------------------
	assign out_free  = !out_valid_q || rsp.ready;
	assign cmd.ready = (state_q == FSM_IDLE) && out_free;
	assign accept    = cmd.valid && cmd.ready;
	assign op        = op_t'(cmd.opcode);

	// push byte position: a fresh record starts at offset zero
	assign off_cur  = push_act_q ? push_off_q : '0;
	assign tgt_cur  = push_act_q ? push_tgt_q : cmd.push_length;
	assign push_cnt = LEN_W'(off_cur) + LEN_W'(1);

	// stored length of the head record, clipped to the built maximum record size
	assign head_len = (len_rd_q > MAX_LEN) ? MAX_LEN : len_rd_q;
	assign idx_plus = LEN_W'(pop_idx_q) + LEN_W'(1);

	// ------------------------------------------------------------------
	// next state and control
	// ------------------------------------------------------------------
	always_comb begin
		state_d     = state_q;
		rd_slot_d   = rd_slot_q;
		wr_slot_d   = wr_slot_q;
		full_d      = full_q;
		empty_d     = empty_q;
		count_d     = count_q;
		push_act_d  = push_act_q;
		push_rej_d  = push_rej_q;
		push_off_d  = push_off_q;
		push_tgt_d  = push_tgt_q;
		cap_d       = cap_q;
		pop_len_d   = pop_len_q;
		pop_idx_d   = pop_idx_q;
		lwr_en      = 1'b0;
		lwr_data    = '0;
		bwr_en      = 1'b0;
		bwr_addr    = {wr_slot_q, off_cur};
		brd_en      = 1'b0;
		brd_addr    = {rd_slot_q, pop_idx_q};
		load_out    = 1'b0;
		res         = '0;
		do_commit   = 1'b0;
		commit_len  = '0;
		do_pop_done = 1'b0;

		unique case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					case (op)
						OP_PUSH: begin
							if (!push_act_q) begin
								if (full_q || cmd.push_length > eff_bytes) begin
									// refused record: one result, rest of it is dropped
									load_out          = 1'b1;
									res.status        = full_q ? RS_FULL : RS_TOO_LONG;
									res.record_length = full_q ? '0 : cmd.push_length;
									res.last_out      = 1'b1;
									push_act_d        = !(cmd.last_in || cmd.push_length == '0);
									push_rej_d        = !(cmd.last_in || cmd.push_length == '0);
									push_off_d        = '0;
								end else if (cmd.push_length == '0) begin
									do_commit  = 1'b1;
									commit_len = '0;
								end else begin
									bwr_en     = 1'b1;
									push_tgt_d = cmd.push_length;
									if (cmd.last_in || push_cnt >= tgt_cur) begin
										do_commit  = 1'b1;
										commit_len = push_cnt;
									end else begin
										push_act_d = 1'b1;
										push_rej_d = 1'b0;
										push_off_d = push_cnt[OFF_W-1:0];
									end
								end
							end else if (push_rej_q) begin
								if (cmd.last_in) begin
									push_act_d = 1'b0;
									push_rej_d = 1'b0;
									push_off_d = '0;
								end
							end else begin
								bwr_en = 1'b1;
								if (cmd.last_in || push_cnt >= tgt_cur) begin
									do_commit  = 1'b1;
									commit_len = push_cnt;
								end else begin
									push_off_d = push_cnt[OFF_W-1:0];
								end
							end
						end
						OP_POP: begin
							if (empty_q) begin
								load_out     = 1'b1;
								res.status   = RS_EMPTY;
								res.last_out = 1'b1;
							end else begin
								// head length is read from the length memory this edge
								cap_d   = cmd.dest_capacity;
								state_d = FSM_POP_LEN;
							end
						end
						OP_CLEAR: begin
							rd_slot_d    = '0;
							wr_slot_d    = '0;
							full_d       = 1'b0;
							empty_d      = 1'b1;
							count_d      = '0;
							push_act_d   = 1'b0;
							push_rej_d   = 1'b0;
							push_off_d   = '0;
							load_out     = 1'b1;
							res.status   = RS_CLEARED;
							res.last_out = 1'b1;
						end
						default: begin
							load_out          = 1'b1;
							res.status        = RS_COUNT;
							res.last_out      = 1'b1;
							res.element_count = count_q;
						end
					endcase
				end
			end
			FSM_POP_LEN: begin
				if (out_free) begin
					if (CAP_W'(head_len) > cap_q) begin
						// destination too small, record stays
						load_out          = 1'b1;
						res.status        = RS_OUT_TOO_LONG;
						res.record_length = head_len;
						res.last_out      = 1'b1;
						state_d           = FSM_IDLE;
					end else if (head_len == '0) begin
						load_out     = 1'b1;
						res.status   = RS_READ_OK;
						res.last_out = 1'b1;
						do_pop_done  = 1'b1;
						state_d      = FSM_IDLE;
					end else begin
						// fetch the first byte
						brd_en    = 1'b1;
						brd_addr  = {rd_slot_q, OFF_W'(0)};
						pop_len_d = head_len;
						pop_idx_d = '0;
						state_d   = FSM_POP_STREAM;
					end
				end
			end
			FSM_POP_STREAM: begin
				if (out_free) begin
					load_out          = 1'b1;
					res.status        = RS_READ_OK;
					res.record_length = pop_len_q;
					res.data_byte     = byte_rd_q;
					res.byte_valid    = 1'b1;
					res.last_out      = (idx_plus == pop_len_q);
					if (idx_plus == pop_len_q) begin
						do_pop_done = 1'b1;
						state_d     = FSM_IDLE;
					end else begin
						// next byte read overlaps with this one leaving
						brd_en    = 1'b1;
						brd_addr  = {rd_slot_q, idx_plus[OFF_W-1:0]};
						pop_idx_d = idx_plus[OFF_W-1:0];
					end
				end
			end
			default: state_d = FSM_IDLE;
		endcase

		// record commit: length goes to its slot and the write pointer moves on
		if (do_commit) begin
			lwr_en            = 1'b1;
			lwr_data          = commit_len;
			wr_slot_d         = wr_next;
			count_d           = (count_q < DEPTH_MAX) ? count_q + CNT_W'(1) : count_q;
			empty_d           = 1'b0;
			full_d            = (wr_next == rd_slot_q);
			push_act_d        = 1'b0;
			push_rej_d        = 1'b0;
			push_off_d        = '0;
			load_out          = 1'b1;
			res.status        = RS_INSERTED;
			res.record_length = commit_len;
			res.last_out      = 1'b1;
		end

		// head record removed
		if (do_pop_done) begin
			count_d   = (count_q != '0) ? count_q - CNT_W'(1) : count_q;
			rd_slot_d = rd_next;
			full_d    = 1'b0;
			empty_d   = (rd_next == wr_slot_q);
		end

		// a register write also empties the queue and drops a push in progress
		if (cfg_wr) begin
			rd_slot_d  = '0;
			wr_slot_d  = '0;
			full_d     = 1'b0;
			empty_d    = 1'b1;
			count_d    = '0;
			push_act_d = 1'b0;
			push_rej_d = 1'b0;
			push_off_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			rd_slot_q   <= '0;
			wr_slot_q   <= '0;
			full_q      <= 1'b0;
			empty_q     <= 1'b1;
			count_q     <= '0;
			push_act_q  <= 1'b0;
			push_rej_q  <= 1'b0;
			push_off_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_slot_q  <= rd_slot_d;
			wr_slot_q  <= wr_slot_d;
			full_q     <= full_d;
			empty_q    <= empty_d;
			count_q    <= count_d;
			push_act_q <= push_act_d;
			push_rej_q <= push_rej_d;
			push_off_q <= push_off_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		push_tgt_q <= push_tgt_d;
		cap_q      <= cap_d;
		pop_len_q  <= pop_len_d;
		pop_idx_q  <= pop_idx_d;
		if (load_out) begin
			out_q <= res;
		end
	end

	// ------------------------------------------------------------------
	// memories
	// ------------------------------------------------------------------
	// length memory: written on commit, head slot read every cycle
	always_ff @(posedge clk) begin
		if (lwr_en) begin
			len_mem[wr_slot_q] <= lwr_data;
		end
		len_rd_q <= len_mem[rd_slot_q];
	end

	// byte memory: push writes, pop reads; read data held while rsp stalls
	always_ff @(posedge clk) begin
		if (bwr_en) begin
			byte_mem[bwr_addr] <= cmd.data_byte_in;
		end
		if (brd_en) begin
			byte_rd_q <= byte_mem[brd_addr];
		end
	end

	// ------------------------------------------------------------------
	// result channel
	// ------------------------------------------------------------------
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_q.status;
	assign rsp.record_length = out_q.record_length;
	assign rsp.data_byte     = out_q.data_byte;
	assign rsp.byte_valid    = out_q.byte_valid;
	assign rsp.last_out      = out_q.last_out;
	assign rsp.element_count = out_q.element_count;

endmodule

`default_nettype wire

>>> verif/vrf_record_checker.sv
// result checker of the variable record fifo: keeps its own copy of the queue
// state, predicts the results of every accepted item and compares them in order
// depends on vrf_pkg, vrf_cmd_if and vrf_rsp_if
`timescale 1ns / 1ps

module vrf_record_checker import vrf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	vrf_cmd_if                 cmd,
	vrf_rsp_if                 rsp,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output int                 mismatches,
	output int                 outstanding
);

	localparam int REPORT_MAX = 10;

	logic [LEN_W-1:0]   slot_bytes;
	logic [DEPTH_W-1:0] slot_limit;
	int                 head, tail, held, fill;
	bit                 is_full, is_empty, in_record, dropping;
	logic [LEN_W-1:0]   len_mem  [BUILT_SLOTS];
	logic [BYTE_W-1:0]  byte_mem [BUILT_SLOTS*MAX_RECORD_BYTES];
	result_t            awaited_results[$];
	int                 errors;

	function automatic int usable_bytes();
		return (slot_bytes > MAX_LEN) ? MAX_RECORD_BYTES : int'(slot_bytes);
	endfunction

	function automatic int usable_slots();
		if (slot_limit == 0) return 1;
		return (slot_limit > DEPTH_MAX) ? BUILT_SLOTS : int'(slot_limit);
	endfunction

	function automatic void expect_result(status_t st, int len, logic [BYTE_W-1:0] b,
			bit bv, bit last, int cnt);
		result_t r;
		r.status        = st;
		r.record_length = LEN_W'(len);
		r.data_byte     = b;
		r.byte_valid    = bv;
		r.last_out      = last;
		r.element_count = CNT_W'(cnt);
		awaited_results.push_back(r);
	endfunction

	function automatic void clear_queue();
		head      = 0;
		tail      = 0;
		held      = 0;
		fill      = 0;
		is_full   = 1'b0;
		is_empty  = 1'b1;
		in_record = 1'b0;
		dropping  = 1'b0;
	endfunction

	function automatic void commit_record(int len);
		len_mem[tail] = LEN_W'(len);
		if (held < BUILT_SLOTS) held++;
		tail++;
		if (tail >= usable_slots()) tail = 0;
		is_empty = 1'b0;
		if (tail == head) is_full = 1'b1;
		in_record = 1'b0;
		dropping  = 1'b0;
		fill      = 0;
		expect_result(RS_INSERTED, len, '0, 1'b0, 1'b1, 0);
	endfunction

	function automatic void take_push(int len, logic [BYTE_W-1:0] b, bit last);
		int target, n;
		if (!in_record) begin
			// accept or refuse is settled on the first item of a record
			if (is_full || len > usable_bytes()) begin
				in_record = !(last || len == 0);
				dropping  = in_record;
				fill      = 0;
				expect_result(is_full ? RS_FULL : RS_TOO_LONG, is_full ? 0 : len, '0,
					1'b0, 1'b1, 0);
				return;
			end
			len_mem[tail] = LEN_W'(len);
			in_record = 1'b1;
			dropping  = 1'b0;
			fill      = 0;
			if (len == 0) begin
				commit_record(0);
				return;
			end
		end else if (dropping) begin
			if (last) begin
				in_record = 1'b0;
				dropping  = 1'b0;
				fill      = 0;
			end
			return;
		end
		target = int'(len_mem[tail]);
		n = fill & 63;
		byte_mem[tail*MAX_RECORD_BYTES + (n % MAX_RECORD_BYTES)] = b;
		n++;
		if (last || n >= target) commit_record(n);
		else fill = n & 63;
	endfunction

	function automatic void take_pop(int cap);
		int len;
		if (is_empty) begin
			expect_result(RS_EMPTY, 0, '0, 1'b0, 1'b1, 0);
			return;
		end
		len = int'(len_mem[head]);
		if (len > MAX_RECORD_BYTES) len = MAX_RECORD_BYTES;
		if (len > cap) begin
			// destination too small: head stays where it is
			expect_result(RS_OUT_TOO_LONG, len, '0, 1'b0, 1'b1, 0);
			return;
		end
		if (len == 0) expect_result(RS_READ_OK, 0, '0, 1'b0, 1'b1, 0);
		for (int i = 0; i < len; i++)
			expect_result(RS_READ_OK, len, byte_mem[head*MAX_RECORD_BYTES + i], 1'b1,
				i == len - 1, 0);
		if (held > 0) held--;
		head++;
		if (head >= usable_slots()) head = 0;
		is_full = 1'b0;
		if (head == tail) is_empty = 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got, want;
		if (!arst_n) begin
			slot_bytes = RECORD_BYTES_RST;
			slot_limit = SLOT_LIM_RST;
			clear_queue();
			awaited_results.delete();
			errors = 0;
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			// a register write also empties the queue and drops a running push
			if (psel && penable && pwrite && pready) begin
				case (cfg_reg_t'(paddr[2]))
					REG_RECORD_BYTES: slot_bytes = pwdata[LEN_W-1:0];
					REG_SLOT_LIM:     slot_limit = pwdata[DEPTH_W-1:0];
				endcase
				clear_queue();
			end
			if (cmd.valid && cmd.ready) begin
				case (op_t'(cmd.opcode))
					OP_PUSH: take_push(int'(cmd.push_length), cmd.data_byte_in, cmd.last_in);
					OP_POP:  take_pop(int'(cmd.dest_capacity));
					OP_CLEAR: begin
						clear_queue();
						expect_result(RS_CLEARED, 0, '0, 1'b0, 1'b1, 0);
					end
					default: expect_result(RS_COUNT, 0, '0, 1'b0, 1'b1, held);
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				got.status        = status_t'(rsp.status);
				got.record_length = rsp.record_length;
				got.data_byte     = rsp.data_byte;
				got.byte_valid    = rsp.byte_valid;
				got.last_out      = rsp.last_out;
				got.element_count = rsp.element_count;
				if (awaited_results.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("%0t: result with none awaited: st=%0d len=%0d byte=%02h",
							$time, got.status, got.record_length, got.data_byte);
				end else begin
					want = awaited_results.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= REPORT_MAX) begin
							$display(
								"%0t: mismatch, expected st=%0d len=%0d byte=%02h bv=%0b last=%0b cnt=%0d",
								$time, want.status, want.record_length, want.data_byte,
								want.byte_valid, want.last_out, want.element_count);
							$display(
								"%0t: mismatch, got      st=%0d len=%0d byte=%02h bv=%0b last=%0b cnt=%0d",
								$time, got.status, got.record_length, got.data_byte,
								got.byte_valid, got.last_out, got.element_count);
						end
					end
				end
			end
			mismatches  <= errors;
			outstanding <= awaited_results.size();
		end
	end

endmodule

>>> verif/tb_top.sv
// top of the variable record fifo testbench: clock, reset, register writes,
// command stimulus and result back-pressure; the verdict comes from the checker
// depends on vrf_pkg, vrf_cmd_if, vrf_rsp_if, vrf_record_checker and the block
`timescale 1ns / 1ps

module tb_top;
	import vrf_pkg::*;

	localparam int HALF_PERIOD  = 5;
	localparam int RESET_CYCLES = 3;
	// far above the slowest correct run: every item with its longest gap and
	// every result behind the longest receiver stall
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int LONG_HOLD    = 150;
	localparam int SETTLE       = 4;
	localparam int TAIL_WAIT    = 8;
	localparam int PHASE_ITEMS  = 4;
	localparam int PHASES       = 7;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite, pready;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata, prdata;

	int mismatches, outstanding;
	int sent_items;
	int hold_reqs;
	int tx_calm;
	int cycles = 0;

	// register settings for the random phases, out-of-range values among them
	int phase_bytes [PHASES] = '{127, 1, 8, 17, 64, 5, 0};
	int phase_slots [PHASES] = '{31, 1, 4, 16, 3, 2, 20};

	vrf_cmd_if cmd_ch ();
	vrf_rsp_if rsp_ch ();

	variable_record_fifo_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	vrf_record_checker result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.rsp         (rsp_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** variable_record_fifo_unit: FAILED **");
			$finish;
		end
	end

	// gap before the next item or ready: mostly none, some short, a few long;
	// now and then a calm stretch with no gaps at all
	function automatic int idle_len(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) calm = $urandom_range(40, 150);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 96) return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// result side: random stalls, and a long hold whenever one is requested
	initial begin : result_sink
		int gap, calm, holds_done;
		gap = 0;
		calm = 0;
		holds_done = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (hold_reqs != holds_done) begin
				// long hold counted here, while the sender keeps offering items
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_done++;
			end else if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				gap--;
			end else begin
				rsp_ch.ready <= 1'b1;
				gap = idle_len(calm);
			end
		end
	end

	// offer one item and hold it until the block takes it
	task automatic send_item(input op_t op, input int len, input int b, input bit last,
			input int cap);
		int gap;
		gap = idle_len(tx_calm);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid         <= 1'b1;
		cmd_ch.opcode        <= op;
		cmd_ch.push_length   <= LEN_W'(len);
		cmd_ch.data_byte_in  <= BYTE_W'(b);
		cmd_ch.last_in       <= last;
		cmd_ch.dest_capacity <= CAP_W'(cap);
		do @(posedge clk); while (cmd_ch.ready !== 1'b1);
		sent_items++;
	endtask

	// push item; the capacity field is unused here so it gets noise
	task automatic push_byte(input int len, input int b, input bit last);
		send_item(OP_PUSH, len, b, last, $urandom_range(0, 65535));
	endtask

	// pop, clear and query ignore the push fields: fill them with noise
	task automatic send_plain(input op_t op, input int cap);
		send_item(op, $urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 1), cap);
	endtask

	// stop offering items until every awaited result is in, then let the
	// block finish any push byte that produces no result
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register write on an idle block: setup cycle, then access until pready
	task automatic write_reg(input cfg_reg_t idx, input int value);
		wait_drained();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(4 * int'(idx));
		pwdata  <= PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// mostly short records, some over the slot, some empty
	function automatic int random_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 0;
		if (r < 20) return $urandom_range(MAX_RECORD_BYTES + 1, 127);
		if (r < 35) return $urandom_range(9, 20);
		return $urandom_range(1, 8);
	endfunction

	function automatic int random_capacity();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return 65535;
		if (r < 70) return $urandom_range(0, 65535);
		return $urandom_range(0, 16);
	endfunction

	// one record, byte by byte; now and then cut short or left without its
	// end mark, and optionally with a pop or query slipped in after the first byte
	task automatic push_record(input int len, input bit interleave);
		int n, cut, r;
		bit keep_last;
		n = (len == 0) ? 1 : len;
		// a refused long record needs only a few items to be dropped
		if (len > MAX_RECORD_BYTES) n = $urandom_range(1, 3);
		cut = n;
		keep_last = 1'b1;
		r = $urandom_range(0, 99);
		if (r < 8) cut = $urandom_range(1, n);
		else if (r < 13) keep_last = 1'b0;
		for (int i = 0; i < cut; i++) begin
			push_byte(i == 0 ? len : $urandom_range(0, 127), $urandom_range(0, 255),
				keep_last && i == cut - 1);
			if (interleave && i == 0 && cut > 1)
				send_plain($urandom_range(0, 1) ? OP_POP : OP_QUERY, random_capacity());
		end
	endtask

	task automatic random_phase(input int budget);
		int stop, r;
		stop = sent_items + budget;
		while (sent_items < stop) begin
			r = $urandom_range(0, 99);
			if (r < 48)
				push_record(random_length(), $urandom_range(0, 9) == 0);
			else if (r < 73)
				send_plain(OP_POP, random_capacity());
			else if (r < 81)
				send_plain(OP_QUERY, random_capacity());
			else if (r < 85)
				send_plain(OP_CLEAR, random_capacity());
			else if (r < 96)
				// stray push item with random fields
				push_byte($urandom_range(0, 127), $urandom_range(0, 255), $urandom_range(0, 1));
			else
				wait_drained();
		end
	endtask

	initial begin : stimulus
		arst_n               = 1'b0;
		psel                 = 1'b0;
		penable              = 1'b0;
		pwrite               = 1'b0;
		paddr                = '0;
		pwdata               = '0;
		cmd_ch.valid         = 1'b0;
		cmd_ch.opcode        = OP_QUERY;
		cmd_ch.push_length   = '0;
		cmd_ch.data_byte_in  = '0;
		cmd_ch.last_in       = 1'b0;
		cmd_ch.dest_capacity = '0;
		sent_items           = 0;
		hold_reqs            = 0;
		tx_calm              = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty block after reset: count and pop
		send_plain(OP_QUERY, 0);
		send_plain(OP_POP, 65535);
		// length-zero record is stored on its first item, payload ignored
		push_byte(0, 8'hff, 1'b1);
		// three bytes, two of them at the byte extremes
		push_byte(3, 8'h00, 1'b0);
		push_byte(127, 8'hff, 1'b0);
		push_byte(0, 8'ha5, 1'b1);
		// early end mark: the stored length is what arrived
		push_byte(5, 8'h5a, 1'b0);
		push_byte(5, 8'hc3, 1'b1);
		// longest length refused, its bytes dropped until the end mark
		push_byte(127, 8'h01, 1'b0);
		push_byte(64, 8'h02, 1'b0);
		push_byte(0, 8'h03, 1'b1);
		// refused record that ends on its first item
		push_byte(65, 8'h04, 1'b1);
		// pop and query in the middle of a push leave it running
		push_byte(2, 8'h11, 1'b0);
		send_plain(OP_QUERY, 0);
		// zero-length head fits a zero-size destination
		send_plain(OP_POP, 0);
		// head too long for the destination, nothing removed
		send_plain(OP_POP, 0);
		push_byte(2, 8'h22, 1'b1);
		send_plain(OP_POP, 65535);
		send_plain(OP_POP, 2);
		// clear drops a push in progress
		push_byte(4, 8'h33, 1'b0);
		send_plain(OP_CLEAR, 0);
		send_plain(OP_QUERY, 0);

		// zero slot size and zero depth: only empty records, one slot
		write_reg(REG_RECORD_BYTES, 0);
		write_reg(REG_SLOT_LIM, 0);
		push_byte(0, 8'h00, 1'b1);
		// full refusal, then a full refusal that drops a byte
		push_byte(0, 8'hff, 1'b1);
		push_byte(1, 8'h5a, 1'b0);
		push_byte(9, 8'ha5, 1'b1);
		send_plain(OP_POP, 65535);
		// any non-empty record is too long for a zero-size slot
		push_byte(1, 8'h81, 1'b1);
		send_plain(OP_QUERY, 0);

		// back-pressure: hold the result side while pushes and pops keep coming
		write_reg(REG_RECORD_BYTES, 64);
		write_reg(REG_SLOT_LIM, 16);
		hold_reqs <= hold_reqs + 1;
		for (int i = 0; i < 3; i++) push_record(6, 1'b0);
		for (int i = 0; i < 3; i++) send_plain(OP_POP, 65535);
		// sender waits for every result before going on
		wait_drained();
		random_phase(PHASE_ITEMS);

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_RECORD_BYTES, phase_bytes[p]);
			write_reg(REG_SLOT_LIM, phase_slots[p]);
			// one full-size record and its pop, once
			if (p == 0) begin
				push_record(MAX_RECORD_BYTES, 1'b0);
				send_plain(OP_POP, 65535);
			end
			random_phase(PHASE_ITEMS);
		end

		wait_drained();
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("** variable_record_fifo_unit: PASSED **");
		else
			$display("** variable_record_fifo_unit: FAILED **");
		$finish;
	end

endmodule
